[rtl/sfcr_pkg.sv]
// Shared types and constants for the separator-framed command ring.
package sfcr_pkg;

  localparam int FRAME_SLOTS_DEF = 4;
  localparam int SLOT_BYTES_DEF  = 64;
  localparam int LEN_W           = 6;
  localparam int BYTE_W          = 8;
  localparam int FUNC_W          = 2;
  localparam int TRAILER_BYTES   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_BYTE = 2'd0,
    FN_POP  = 2'd1,
    FN_DROP = 2'd2
  } func_t;

  typedef enum logic [0:0] {
    S_IDLE   = 1'b0,
    S_STREAM = 1'b1
  } state_t;

  typedef struct packed {
    logic byte_step;
    logic drop;
    logic pop_start;
    logic issue_read;
    logic load_out;
    logic load_empty;
  } cmd_t;

  typedef struct packed {
    logic pop_empty;
    logic rd_more;
    logic buf_valid;
    logic buf_last;
    logic out_free;
  } stat_t;

endpackage

[rtl/sfcr_ctrl.sv]
// Controller state machine: decodes transactions and sequences frame pops.
module sfcr_ctrl
  import sfcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [FUNC_W-1:0] func,
  input  stat_t             stat,
  output cmd_t              cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (func)
            FN_BYTE: cmd.byte_step = 1'b1;
            FN_POP: begin
              cmd.pop_start = 1'b1;
              state_next    = S_STREAM;
            end
            FN_DROP: cmd.drop = 1'b1;
            default: ;
          endcase
        end
      end
      S_STREAM: begin
        if (stat.pop_empty) begin
          cmd.load_empty = stat.out_free;
          if (stat.out_free) begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.load_out   = stat.buf_valid && stat.out_free;
          cmd.issue_read = stat.rd_more && (!stat.buf_valid || cmd.load_out);
          if (cmd.load_out && stat.buf_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/sfcr_datapath.sv]
// Datapath: slot memory, ring pointers, frame assembly and output register.
module sfcr_datapath
  import sfcr_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
  parameter int SLOT_BYTES  = SLOT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);

  localparam int SLOT_W  = $clog2(FRAME_SLOTS);
  localparam int IDX_W   = $clog2(SLOT_BYTES);
  localparam int END_W   = IDX_W + 1;
  localparam int ADDR_W  = SLOT_W + IDX_W;
  localparam int DEPTH   = FRAME_SLOTS * (2 ** IDX_W);
  localparam int CAP     = SLOT_BYTES - 1;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [BYTE_W-1:0] separator;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic              assembling;
  logic [IDX_W-1:0]  byte_index;
  logic [END_W-1:0]  end_index;
  logic              sep_seen;
  logic [LEN_W-1:0]  slot_count [FRAME_SLOTS];

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata;
  logic              buf_valid;
  logic              buf_last;
  logic [SLOT_W-1:0] pop_slot;
  logic [LEN_W-1:0]  frame_len;
  logic [LEN_W-1:0]  rd_idx;

  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  out_len;
  logic              out_none;
  logic              out_last;

  // frame assembly step
  logic              open_now;
  logic              act;
  logic [IDX_W-1:0]  idx_cur;
  logic [IDX_W-1:0]  idx_new;
  logic              sep_cur;
  logic [END_W-1:0]  end_cur;
  logic [END_W-1:0]  end_new;
  logic              hit;
  logic              done;
  logic              wr_en;

  // pop setup
  logic [SLOT_W-1:0] rp;
  logic              has_frame;

  always_comb begin
    open_now = !assembling && (next_slot(head) != tail);
    act      = assembling || open_now;
    idx_cur  = open_now ? '0 : byte_index;
    sep_cur  = open_now ? 1'b0 : sep_seen;
    end_cur  = open_now ? END_W'(SLOT_BYTES) : end_index;
    wr_en    = cmd.byte_step && act && (idx_cur < IDX_W'(CAP));
    idx_new  = (idx_cur < IDX_W'(CAP)) ? idx_cur + 1'b1 : idx_cur;
    hit      = !sep_cur && (rx_byte == separator);
    end_new  = hit ? END_W'(idx_new) + END_W'(TRAILER_BYTES) : end_cur;
    done     = (END_W'(idx_new) == end_new) || (idx_new >= IDX_W'(CAP));
    rp        = next_slot(tail);
    has_frame = (rp != head);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator  <= '0;
      head       <= '0;
      tail       <= SLOT_W'(FRAME_SLOTS - 1);
      assembling <= 1'b0;
      byte_index <= '0;
      end_index  <= '0;
      sep_seen   <= 1'b0;
      frame_len  <= '0;
      rd_idx     <= '0;
      buf_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        separator <= cfg_data;
      end
      if (cmd.byte_step && act) begin
        end_index <= end_new;
        if (done) begin
          head       <= next_slot(head);
          assembling <= 1'b0;
          byte_index <= '0;
          sep_seen   <= 1'b0;
        end else begin
          assembling <= 1'b1;
          byte_index <= idx_new;
          sep_seen   <= sep_cur | hit;
        end
      end
      if (cmd.drop) begin
        assembling <= 1'b0;
        byte_index <= '0;
        sep_seen   <= 1'b0;
      end
      if (cmd.pop_start) begin
        if (has_frame) begin
          tail <= rp;
        end
        frame_len <= has_frame ? slot_count[rp] : '0;
        rd_idx    <= '0;
        buf_valid <= 1'b0;
      end
      if (cmd.issue_read) begin
        rd_idx    <= rd_idx + 1'b1;
        buf_valid <= 1'b1;
      end else if (cmd.load_out) begin
        buf_valid <= 1'b0;
      end
      if (cmd.load_out || cmd.load_empty) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_step && act) begin
      slot_count[head] <= LEN_W'(idx_new);
    end
    if (cmd.pop_start) begin
      pop_slot <= rp;
    end
    if (cmd.issue_read) begin
      buf_last <= ((rd_idx + 1'b1) == frame_len);
    end
    if (cmd.load_out) begin
      out_byte <= rdata;
      out_len  <= frame_len;
      out_none <= 1'b0;
      out_last <= buf_last;
    end else if (cmd.load_empty) begin
      out_byte <= '0;
      out_len  <= '0;
      out_none <= 1'b1;
      out_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{head, idx_cur}] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_read) begin
      rdata <= mem[ADDR_W'({pop_slot, rd_idx[IDX_W-1:0]})];
    end
  end

  always_comb begin
    stat.pop_empty = (frame_len == '0);
    stat.rd_more   = (rd_idx != frame_len);
    stat.buf_valid = buf_valid;
    stat.buf_last  = buf_last;
    stat.out_free  = !m_tvalid || m_tready;
  end

  assign m_tdata = {2'b00, out_len, out_byte};
  assign m_tuser = out_none;
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_head_tail_apart: assert property (@(posedge clk) disable iff (rst) head != tail)
    else $error("write slot collides with last popped slot");
  a_index_in_slot: assert property (@(posedge clk) disable iff (rst)
    byte_index < IDX_W'(CAP))
    else $error("byte index past slot capacity");
  a_no_buf_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |-> (!buf_valid || cmd.load_out))
    else $error("read buffer overwritten before transfer");
  a_no_out_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out || cmd.load_empty) |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while stalled");
  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |-> (rd_idx < frame_len))
    else $error("read beyond frame length");
`endif

endmodule

[rtl/separator_framed_command_ring.sv]
// Top level of the separator-framed command ring.
//
//  group | dir | signals                        | contents (low bit up)
//  s_*   | in  | s_tvalid s_tready s_tdata s_tuser | tdata: rx_byte; tuser: func
//  m_*   | out | m_tvalid m_tready m_tdata m_tuser m_tlast | frame_byte, frame_length
//  cfg_* | in  | cfg_valid cfg_ready cfg_data   | separator_byte
//
// Received byte and drop transactions are taken back to back. A pop is accepted, then
// streams len bytes at one per cycle from the single slot memory read port. No further
// transaction is taken while a pop streams; output stalls hold the stream.
// Synchronous reset; slot memory and counts are not cleared and need no sweep.
module separator_framed_command_ring
  import sfcr_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
  parameter int SLOT_BYTES  = SLOT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic [FUNC_W-1:0] s_tuser,   // [1:0] func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [7:0] frame_byte, [13:8] frame_length, [15:14] zero
  output logic              m_tuser,   // [0] no_frame
  output logic              m_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data   // [7:0] separator_byte
);

  cmd_t  cmd;
  stat_t stat;

  sfcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfcr_datapath #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .SLOT_BYTES  (SLOT_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[bench/tb_separator_framed_command_ring.sv]
// Self-checking testbench for the separator-framed command ring: directed table, then random.
`timescale 1ns / 1ps

module tb_separator_framed_command_ring;
  import sfcr_pkg::*;

  localparam int SLOTS = FRAME_SLOTS_DEF;
  localparam int BYTES = SLOT_BYTES_DEF;
  localparam int CAP   = BYTES - 1;
  localparam logic [FUNC_W-1:0] FN_RESERVED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 15;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [LEN_W-1:0] frame_len;
    logic             no_frame;
    logic             last_byte;
  } frame_beat_t;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [7:0]        data;
    logic              fixed;
    frame_beat_t       want;
  } dir_row_t;

  localparam frame_beat_t EMPTY_POP = '{8'h00, 6'd0, 1'b1, 1'b1};
  localparam frame_beat_t NO_BEAT   = '0;

  // Runs under the reset separator 0x00.
  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{FN_POP,      8'h00, 1'b1, EMPTY_POP},
    '{FN_DROP,     8'h00, 1'b0, NO_BEAT},
    '{FN_RESERVED, 8'hA5, 1'b0, NO_BEAT},
    '{FN_POP,      8'hFF, 1'b1, EMPTY_POP},
    '{FN_BYTE,     8'h00, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'hFF, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'hA5, 1'b0, NO_BEAT},
    '{FN_POP,      8'h00, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h55, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h00, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h00, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h7E, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h12, 1'b0, NO_BEAT},
    '{FN_DROP,     8'h00, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h80, 1'b0, NO_BEAT},
    '{FN_POP,      8'h00, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h00, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h01, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'hFE, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h00, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h11, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h22, 1'b0, NO_BEAT},
    '{FN_BYTE,     8'h99, 1'b0, NO_BEAT},
    '{FN_POP,      8'h00, 1'b0, NO_BEAT},
    '{FN_POP,      8'h00, 1'b0, NO_BEAT},
    '{FN_POP,      8'h00, 1'b1, EMPTY_POP}
  };

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;
  logic [FUNC_W-1:0] s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_data;

  separator_framed_command_ring dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ring predictor state
  logic [7:0]       sep_cfg;
  logic [7:0]       slot_mem [SLOTS*BYTES];
  logic [LEN_W-1:0] slot_len [SLOTS];
  int               head_slot;
  int               tail_slot;
  bit               asm_open;
  logic [5:0]       fill;
  logic [6:0]       end_at;
  bit               sep_found;

  frame_beat_t popped_beats [$];
  int          fault_cnt;
  int          taken_cnt;
  bit          calm;
  bit          hold_req;
  int          hold_cnt;
  frame_beat_t got;
  frame_beat_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_separator_framed_command_ring: FAIL");
    $finish;
  end

  task automatic ring_apply(input logic [FUNC_W-1:0] fn, input logic [7:0] b);
    int          rp;
    int          n;
    frame_beat_t beat;
    case (fn)
      FN_BYTE: begin
        if (!asm_open && (head_slot + 1) % SLOTS != tail_slot) begin
          asm_open  = 1'b1;
          fill      = '0;
          end_at    = 7'(BYTES);
          sep_found = 1'b0;
        end
        if (asm_open) begin
          if (fill < CAP) begin
            slot_mem[head_slot*BYTES + int'(fill)] = b;
            fill = fill + 6'd1;
          end
          slot_len[head_slot] = fill;
          if (!sep_found && b == sep_cfg) begin
            sep_found = 1'b1;
            end_at    = {1'b0, fill} + 7'd2;
          end
          if ({1'b0, fill} == end_at || fill >= CAP) begin
            head_slot = (head_slot + 1) % SLOTS;
            asm_open  = 1'b0;
            fill      = '0;
            sep_found = 1'b0;
          end
        end
      end
      FN_POP: begin
        rp = (tail_slot + 1) % SLOTS;
        if (rp == head_slot) begin
          popped_beats.push_back(EMPTY_POP);
        end else begin
          tail_slot = rp;
          n = int'(slot_len[rp]);
          if (n == 0) begin
            popped_beats.push_back(EMPTY_POP);
          end
          for (int i = 0; i < n; i++) begin
            beat.frame_byte = slot_mem[rp*BYTES + i];
            beat.frame_len  = slot_len[rp];
            beat.no_frame   = 1'b0;
            beat.last_byte  = (i == n - 1);
            popped_beats.push_back(beat);
          end
        end
      end
      FN_DROP: begin
        asm_open  = 1'b0;
        fill      = '0;
        sep_found = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [7:0] b,
                           input bit fixed, input frame_beat_t fixed_beat);
    int before_n;
    if (!calm && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    before_n = popped_beats.size();
    ring_apply(fn, b);
    if (fixed) begin
      while (popped_beats.size() > before_n) popped_beats.delete(popped_beats.size() - 1);
      popped_beats.push_back(fixed_beat);
    end
    taken_cnt++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int pre);
    logic [7:0] b;
    for (int i = 0; i < pre; i++) begin
      b = 8'($urandom_range(255));
      if (b == sep_cfg) b = b ^ 8'h01;
      send_item(FN_BYTE, b, 1'b0, NO_BEAT);
    end
    send_item(FN_BYTE, sep_cfg, 1'b0, NO_BEAT);
    send_item(FN_BYTE, 8'($urandom_range(255)), 1'b0, NO_BEAT);
    send_item(FN_BYTE, 8'($urandom_range(255)), 1'b0, NO_BEAT);
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      if ($urandom_range(99) < 4) send_frame($urandom_range(60, 64));
      else send_frame($urandom_range(0, 4));
    end else if (r < 80) begin
      send_item(FN_POP, 8'($urandom_range(255)), 1'b0, NO_BEAT);
    end else if (r < 88) begin
      repeat ($urandom_range(0, 3)) send_item(FN_BYTE, 8'($urandom_range(255)), 1'b0, NO_BEAT);
      send_item(FN_DROP, 8'($urandom_range(255)), 1'b0, NO_BEAT);
    end else if (r < 94) begin
      send_item(FN_BYTE, 8'($urandom_range(255)), 1'b0, NO_BEAT);
    end else begin
      send_item(FN_RESERVED, 8'($urandom_range(255)), 1'b0, NO_BEAT);
    end
  endtask

  // Called at a falling edge; returns at a falling edge with the ring idle.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (popped_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_separator(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sep_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_cnt = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cnt > 0) begin
        m_tready <= 1'b0;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 25);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tdata[13:8], m_tuser, m_tlast};
      if (popped_beats.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("unexpected transaction: byte %02h len %0d none %0b last %0b",
                   got.frame_byte, got.frame_len, got.no_frame, got.last_byte);
      end else begin
        want = popped_beats.pop_front();
        if (got !== want) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("mismatch: exp byte %02h len %0d none %0b last %0b, %s %02h %0d %0b %0b",
                     want.frame_byte, want.frame_len, want.no_frame, want.last_byte,
                     "got", got.frame_byte, got.frame_len, got.no_frame, got.last_byte);
        end
      end
    end
  end

  initial begin
    logic [7:0] seps [4];
    int         start;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    fault_cnt = 0;
    taken_cnt = 0;
    sep_cfg   = 8'h00;
    head_slot = 0;
    tail_slot = SLOTS - 1;
    asm_open  = 1'b0;
    fill      = '0;
    end_at    = '0;
    sep_found = 1'b0;
    for (int i = 0; i < SLOTS*BYTES; i++) slot_mem[i] = 8'h00;
    for (int i = 0; i < SLOTS; i++) slot_len[i] = '0;
    seps[0] = 8'hFF;
    seps[1] = 8'($urandom_range(255));
    seps[2] = 8'h00;
    seps[3] = 8'($urandom_range(255));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIR_TABLE[i].fn, DIR_TABLE[i].data, DIR_TABLE[i].fixed, DIR_TABLE[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drain();
      write_separator(seps[ph]);
      calm = (ph == 2);
      // two pops under the hold-off: at least one cannot complete, so the input stalls
      if (ph == 1) begin
        hold_req = 1'b1;
        repeat (2) send_item(FN_POP, 8'h00, 1'b0, NO_BEAT);
      end
      // slot-full frame with the separator too late to matter
      if (ph == 3) begin
        repeat (2) send_item(FN_POP, 8'h00, 1'b0, NO_BEAT);
        send_frame(63);
      end
      start = taken_cnt;
      while (taken_cnt - start < PHASE_ITEMS) random_step();
    end
    repeat (3) send_item(FN_POP, 8'h00, 1'b0, NO_BEAT);
    wait_drain();
    repeat (10) @(posedge clk);

    if (fault_cnt == 0 && popped_beats.size() == 0) begin
      $display("tb_separator_framed_command_ring: PASS");
    end else begin
      if (popped_beats.size() != 0)
        $display("%0d expected transactions never arrived", popped_beats.size());
      $display("tb_separator_framed_command_ring: FAIL");
    end
    $finish;
  end

endmodule

[separator_framed_command_ring.f]
rtl/sfcr_pkg.sv
rtl/sfcr_ctrl.sv
rtl/sfcr_datapath.sv
rtl/separator_framed_command_ring.sv
bench/tb_separator_framed_command_ring.sv
